/* src/pidc_pkg.sv */
// Package for the PID controller: widths, register map, microcode format and program.
// No dependencies; used by the interfaces, the top level and the checker.
package pidc_pkg;

	localparam int SAMPLE_W = 16;
	localparam int ACC_W    = 32;
	localparam int GAIN_W   = 16;
	localparam int ERR_W    = SAMPLE_W + 1;
	localparam int DIFF_W   = SAMPLE_W + 2;
	localparam int MUL_A_W  = ACC_W;
	localparam int MUL_B_W  = GAIN_W + 1;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int SUM_W    = PROD_W + 2;
	localparam int INTEG_SHIFT = 16;
	localparam int OUT_SHIFT   = 8;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_PROP_GAIN  = 3'd0,
		REG_INTEG_GAIN = 3'd1,
		REG_DERIV_GAIN = 3'd2,
		REG_TIME_STEP  = 3'd3,
		REG_TIME_RECIP = 3'd4
	} reg_idx_t;

	localparam logic [GAIN_W-1:0] TIME_RECIP_RST = GAIN_W'(1);

	typedef enum logic [1:0] {
		A_ERR,
		A_DIFF,
		A_INTEG,
		A_SLOPE
	} a_sel_t;

	typedef enum logic [2:0] {
		B_DT,
		B_RECIP,
		B_KP,
		B_KI,
		B_KD
	} b_sel_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INTEG,
		OP_SLOPE,
		OP_LOAD,
		OP_ADD_I,
		OP_OUT
	} acc_op_t;

	typedef struct packed {
		a_sel_t  a_sel;
		b_sel_t  b_sel;
		acc_op_t op;
		logic    last;
	} ucode_t;

	localparam int UCODE_LEN = 6;
	localparam int STEP_W    = $clog2(UCODE_LEN);

	// multiplier result lands in the product register one step before its use
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = '{a_sel: A_ERR, b_sel: B_DT, op: OP_NONE, last: 1'b0};
		unique case (step)
			STEP_W'(0): w = '{a_sel: A_ERR,   b_sel: B_DT,    op: OP_NONE,  last: 1'b0};
			STEP_W'(1): w = '{a_sel: A_DIFF,  b_sel: B_RECIP, op: OP_INTEG, last: 1'b0};
			STEP_W'(2): w = '{a_sel: A_ERR,   b_sel: B_KP,    op: OP_SLOPE, last: 1'b0};
			STEP_W'(3): w = '{a_sel: A_INTEG, b_sel: B_KI,    op: OP_LOAD,  last: 1'b0};
			STEP_W'(4): w = '{a_sel: A_SLOPE, b_sel: B_KD,    op: OP_ADD_I, last: 1'b0};
			STEP_W'(5): w = '{a_sel: A_ERR,   b_sel: B_DT,    op: OP_OUT,   last: 1'b1};
			default:    w = '{a_sel: A_ERR,   b_sel: B_DT,    op: OP_NONE,  last: 1'b1};
		endcase
		return w;
	endfunction

	// clamp to the signed accumulator range
	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] x);
		logic [SUM_W-ACC_W:0] top;
		top = x[SUM_W-1:ACC_W-1];
		if (top == '0 || top == '1) begin
			return x[ACC_W-1:0];
		end
		return x[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
	endfunction

endpackage

/* src/pidc_ifs.sv */
// Stream interfaces of the PID controller: sample input and drive output.
// Depends on pidc_pkg for the field widths.
interface pidc_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [pidc_pkg::SAMPLE_W-1:0] target;
	logic signed [pidc_pkg::SAMPLE_W-1:0] measured;

	modport source(output valid, output target, output measured, input ready);
	modport sink(input valid, input target, input measured, output ready);
endinterface

interface pidc_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [pidc_pkg::ACC_W-1:0] drive;

	modport source(output valid, output drive, input ready);
	modport sink(input valid, input drive, output ready);
endinterface

/* src/pid_controller_top.sv */
// PID controller top level: APB register file, microcode sequencer and shared datapath.
// Depends on pidc_pkg and the stream interfaces in pidc_ifs.sv.
//
// One sample transfer yields one drive transfer. The sample is registered on its transfer, then
// a six-word microcode program runs one word per cycle through a single 32x17 multiplier;
// drive is registered by the final step, and no new sample is taken until that step is done.
// The final step holds while the drive register is still full. Gains are signed Q8.8, the
// time step is unsigned Q0.16 and its reciprocal an unsigned integer that software keeps
// consistent; integral, slope and drive saturate to 32-bit signed. Registers are to be
// written only while no sample is in flight; the block itself does not enforce this.
module pid_controller_top (
	input  logic                                clk,
	input  logic                                arst_n,
	pidc_in_if.sink                             sample_in,
	pidc_out_if.source                          result_out,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pidc_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [pidc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [pidc_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	logic signed [pidc_pkg::GAIN_W-1:0]   prop_gain_q, integ_gain_q, deriv_gain_q;
	logic        [pidc_pkg::GAIN_W-1:0]   time_step_q, time_recip_q;
	logic                                 cfg_wr;
	pidc_pkg::reg_idx_t                   reg_idx;

	logic                                 busy_q;
	logic [pidc_pkg::STEP_W-1:0]          step_q;
	pidc_pkg::ucode_t                     ctrl;
	logic                                 step_en;
	logic                                 in_xfer;

	logic signed [pidc_pkg::ERR_W-1:0]    err_c, err_q, last_err_q;
	logic signed [pidc_pkg::DIFF_W-1:0]   diff_q;
	logic signed [pidc_pkg::ACC_W-1:0]    integ_q, slope_q, drive_q;
	logic signed [pidc_pkg::MUL_A_W-1:0]  mul_a;
	logic signed [pidc_pkg::MUL_B_W-1:0]  mul_b;
	logic signed [pidc_pkg::PROD_W-1:0]   prod_c, prod_q;
	logic signed [pidc_pkg::SUM_W-1:0]    acc_q, sum_c;
	logic                                 out_valid_q;

	// register file
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = pidc_pkg::reg_idx_t'(paddr[pidc_pkg::APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= '0;
			integ_gain_q <= '0;
			deriv_gain_q <= '0;
			time_step_q  <= '0;
			time_recip_q <= pidc_pkg::TIME_RECIP_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				pidc_pkg::REG_PROP_GAIN:  prop_gain_q  <= pwdata[pidc_pkg::GAIN_W-1:0];
				pidc_pkg::REG_INTEG_GAIN: integ_gain_q <= pwdata[pidc_pkg::GAIN_W-1:0];
				pidc_pkg::REG_DERIV_GAIN: deriv_gain_q <= pwdata[pidc_pkg::GAIN_W-1:0];
				pidc_pkg::REG_TIME_STEP:  time_step_q  <= pwdata[pidc_pkg::GAIN_W-1:0];
				pidc_pkg::REG_TIME_RECIP: time_recip_q <= pwdata[pidc_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			pidc_pkg::REG_PROP_GAIN:  prdata = {16'b0, prop_gain_q};
			pidc_pkg::REG_INTEG_GAIN: prdata = {16'b0, integ_gain_q};
			pidc_pkg::REG_DERIV_GAIN: prdata = {16'b0, deriv_gain_q};
			pidc_pkg::REG_TIME_STEP:  prdata = {16'b0, time_step_q};
			pidc_pkg::REG_TIME_RECIP: prdata = {16'b0, time_recip_q};
			default:                  prdata = '0;
		endcase
	end

	// sequencer
	assign sample_in.ready = !busy_q;
	assign in_xfer = sample_in.valid && !busy_q;
	assign ctrl    = pidc_pkg::ucode_rom(step_q);
	// last word waits for room in the drive register
	assign step_en = busy_q && (!(ctrl.last) || !out_valid_q || result_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (in_xfer) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (step_en) begin
			if (ctrl.last) begin
				busy_q <= 1'b0;
				step_q <= '0;
			end else begin
				step_q <= step_q + pidc_pkg::STEP_W'(1);
			end
		end
	end

	// datapath
	assign err_c = pidc_pkg::ERR_W'(sample_in.target) - pidc_pkg::ERR_W'(sample_in.measured);

	always_comb begin
		case (ctrl.a_sel)
			pidc_pkg::A_ERR:   mul_a = pidc_pkg::MUL_A_W'(err_q);
			pidc_pkg::A_DIFF:  mul_a = pidc_pkg::MUL_A_W'(diff_q);
			pidc_pkg::A_INTEG: mul_a = integ_q;
			pidc_pkg::A_SLOPE: mul_a = slope_q;
			default:           mul_a = '0;
		endcase
		case (ctrl.b_sel)
			pidc_pkg::B_DT:    mul_b = {1'b0, time_step_q};
			pidc_pkg::B_RECIP: mul_b = {1'b0, time_recip_q};
			pidc_pkg::B_KP:    mul_b = pidc_pkg::MUL_B_W'(prop_gain_q);
			pidc_pkg::B_KI:    mul_b = pidc_pkg::MUL_B_W'(integ_gain_q);
			pidc_pkg::B_KD:    mul_b = pidc_pkg::MUL_B_W'(deriv_gain_q);
			default:           mul_b = '0;
		endcase
	end

	assign prod_c = mul_a * mul_b;
	assign sum_c  = acc_q + pidc_pkg::SUM_W'(prod_q);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			err_q  <= err_c;
			diff_q <= pidc_pkg::DIFF_W'(err_c) - pidc_pkg::DIFF_W'(last_err_q);
		end
		if (step_en) begin
			prod_q <= prod_c;
			case (ctrl.op)
				pidc_pkg::OP_LOAD:  acc_q <= pidc_pkg::SUM_W'(prod_q);
				pidc_pkg::OP_ADD_I: acc_q <= acc_q +
					pidc_pkg::SUM_W'(prod_q >>> pidc_pkg::INTEG_SHIFT);
				pidc_pkg::OP_OUT:   drive_q <= pidc_pkg::sat_acc(sum_c >>> pidc_pkg::OUT_SHIFT);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q  <= '0;
			integ_q     <= '0;
			slope_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				last_err_q <= err_c;
			end
			if (step_en && ctrl.op == pidc_pkg::OP_INTEG) begin
				integ_q <= pidc_pkg::sat_acc(pidc_pkg::SUM_W'(integ_q) +
					pidc_pkg::SUM_W'(prod_q));
			end
			if (step_en && ctrl.op == pidc_pkg::OP_SLOPE) begin
				slope_q <= pidc_pkg::sat_acc(pidc_pkg::SUM_W'(prod_q));
			end
			if (step_en && ctrl.op == pidc_pkg::OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.drive = drive_q;

endmodule

/* src/pidc_checker.sv */
// Port-level checker for pid_controller_top, attached by the bind at the end of this file.
// Depends on pidc_pkg for the drive width.
module pidc_sva (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [pidc_pkg::ACC_W-1:0] drive
);

	logic       in_xfer, out_xfer;
	logic [1:0] pend_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// samples taken but drive not yet transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> pend_q != 2'd2)
		else $error("sample taken with two results outstanding");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("drive valid without a pending sample");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("ready stayed high after a sample transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive))
		else $error("stalled drive changed or dropped");

endmodule

bind pid_controller_top pidc_sva u_pidc_sva (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample_in.valid),
	.in_ready  (sample_in.ready),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.drive     (result_out.drive)
);
